/* hdl/uvsd_pkg.sv */
// Package: shared types, codes and constants for the unique value set difference block.
package uvsd_pkg;

    // Default number of table entries
    localparam int VALUE_RANGE_DEF = 64;
    // Item values are 6 bits wide, so no more than this many entries can be loaded
    localparam int MAX_LOAD = 64;

    localparam int VALUE_W = 6;
    localparam int COUNT_W = 7;

    // Action codes
    localparam logic [1:0] ACT_FIRST  = 2'd0;
    localparam logic [1:0] ACT_SECOND = 2'd1;
    localparam logic [1:0] ACT_FINISH = 2'd2;

    // Saturating occurrence count codes
    localparam logic [1:0] CNT_NONE = 2'd0;
    localparam logic [1:0] CNT_ONCE = 2'd1;
    localparam logic [1:0] CNT_MANY = 2'd2;

    typedef struct packed {
        logic [1:0]         action;
        logic [VALUE_W-1:0] item_value;
    } t_in_word;

    typedef struct packed {
        logic [VALUE_W-1:0] result_value;
        logic [COUNT_W-1:0] result_count;
        logic               none_found;
        logic               is_last;
    } t_out_word;

    // One table entry: first-sequence count and second-sequence presence
    typedef struct packed {
        logic [1:0] cnt;
        logic       pres;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

endpackage

/* hdl/uvsd_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module uvsd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* hdl/unique_value_set_difference.sv */
// Top level: per-value tables of two sequences and an ascending scan that emits singletons.
// A load word is read from the table, then written back in S_LOAD; ready is low in between.
// A finish word reads min(VALUE_RANGE,64) entries, each in S_SCAN_RD then S_SCAN_EV, and closes
// in S_END; the scan waits until an emitted word is taken before it reads the next entry.
// A result leaves when the next singleton is found; the last one leaves at the close.
// Reset (synchronous, active low) clears all entry valid bits, so both tables read as zero.
module unique_value_set_difference
    import uvsd_pkg::*;
#(
    parameter int VALUE_RANGE = VALUE_RANGE_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_word  i_in,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_word o_out
);

    localparam int DEPTH = (VALUE_RANGE < MAX_LOAD) ? VALUE_RANGE : MAX_LOAD;
    localparam int AW    = $clog2(DEPTH);

    typedef enum logic [4:0] {
        S_IDLE    = 5'b00001,
        S_LOAD    = 5'b00010,
        S_SCAN_RD = 5'b00100,
        S_SCAN_EV = 5'b01000,
        S_END     = 5'b10000
    } t_state;

    t_state             r_state, n_state;
    logic [DEPTH-1:0]   r_valid, n_valid;
    logic               r_rd_vld, n_rd_vld;
    logic [AW-1:0]      r_idx, n_idx;
    logic               r_is_first, n_is_first;
    logic [COUNT_W-1:0] r_count, n_count;
    logic               r_pend, n_pend;
    logic [AW-1:0]      r_pend_val, n_pend_val;
    logic               r_out_valid, n_out_valid;
    t_out_word          r_out, n_out;

    logic               in_fire;
    logic               out_fire;
    logic               in_range;
    logic [AW-1:0]      in_addr;
    logic [AW-1:0]      raddr;
    logic               we;
    t_entry             rd_entry;
    t_entry             wr_entry;
    logic [ENTRY_W-1:0] ram_rdata;
    logic               qual;
    logic               idx_last;

    uvsd_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (DEPTH)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (r_idx),
        .i_wdata (wr_entry),
        .i_raddr (raddr),
        .o_rdata (ram_rdata)
    );

    assign o_in_ready  = (r_state == S_IDLE);
    assign in_fire     = i_in_valid && o_in_ready;
    assign out_fire    = r_out_valid && i_out_ready;
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    assign in_range = ({1'b0, i_in.item_value} < COUNT_W'(DEPTH));
    assign in_addr  = i_in.item_value[AW-1:0];
    assign raddr    = (r_state == S_IDLE) ? in_addr : r_idx;
    assign idx_last = (r_idx == AW'(DEPTH - 1));

    // Entries never written since the last clear read as zero
    assign rd_entry = r_rd_vld ? t_entry'(ram_rdata) : t_entry'('0);
    assign qual     = (rd_entry.cnt == CNT_ONCE) && !rd_entry.pres;
    assign we       = (r_state == S_LOAD);

    // Update the loaded entry: bump the saturating count or mark presence
    always_comb begin
        wr_entry = rd_entry;
        if (r_is_first) begin
            if (rd_entry.cnt != CNT_MANY) begin
                wr_entry.cnt = rd_entry.cnt + 2'd1;
            end
        end else begin
            wr_entry.pres = 1'b1;
        end
    end

    // Sequencer
    always_comb begin
        n_state     = r_state;
        n_valid     = r_valid;
        n_rd_vld    = r_valid[raddr];
        n_idx       = r_idx;
        n_is_first  = r_is_first;
        n_count     = r_count;
        n_pend      = r_pend;
        n_pend_val  = r_pend_val;
        n_out_valid = r_out_valid && !out_fire;
        n_out       = r_out;

        case (r_state)
            S_IDLE: begin
                if (in_fire) begin
                    if ((i_in.action == ACT_FIRST || i_in.action == ACT_SECOND) && in_range) begin
                        n_idx      = in_addr;
                        n_is_first = (i_in.action == ACT_FIRST);
                        n_state    = S_LOAD;
                    end else if (i_in.action == ACT_FINISH) begin
                        n_idx   = '0;
                        n_count = '0;
                        n_pend  = 1'b0;
                        n_state = S_SCAN_RD;
                    end
                end
            end
            S_LOAD: begin
                n_valid[r_idx] = 1'b1;
                n_state        = S_IDLE;
            end
            S_SCAN_RD: begin
                // hold until the output word is free
                if (!r_out_valid) begin
                    n_state = S_SCAN_EV;
                end
            end
            S_SCAN_EV: begin
                if (qual) begin
                    if (r_pend) begin
                        n_out_valid        = 1'b1;
                        n_out.result_value = VALUE_W'(r_pend_val);
                        n_out.result_count = r_count + COUNT_W'(1);
                        n_out.none_found   = 1'b0;
                        n_out.is_last      = 1'b0;
                        n_count            = r_count + COUNT_W'(1);
                    end
                    n_pend     = 1'b1;
                    n_pend_val = r_idx;
                end
                if (idx_last) begin
                    n_state = S_END;
                end else begin
                    n_idx   = r_idx + AW'(1);
                    n_state = S_SCAN_RD;
                end
            end
            S_END: begin
                // emit the held singleton as last, or the empty-set word; then drop the tables
                if (!r_out_valid) begin
                    n_out_valid = 1'b1;
                    if (r_pend) begin
                        n_out.result_value = VALUE_W'(r_pend_val);
                        n_out.result_count = r_count + COUNT_W'(1);
                        n_out.none_found   = 1'b0;
                    end else begin
                        n_out.result_value = '0;
                        n_out.result_count = '0;
                        n_out.none_found   = 1'b1;
                    end
                    n_out.is_last = 1'b1;
                    n_pend        = 1'b0;
                    n_valid       = '0;
                    n_state       = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_valid     <= '0;
            r_out_valid <= 1'b0;
            r_pend      <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_valid     <= n_valid;
            r_out_valid <= n_out_valid;
            r_pend      <= n_pend;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_rd_vld   <= n_rd_vld;
        r_idx      <= n_idx;
        r_is_first <= n_is_first;
        r_count    <= n_count;
        r_pend_val <= n_pend_val;
        r_out      <= n_out;
    end

endmodule

/* tb/sv/tb_unique_value_set_difference.sv */
// Testbench for the unique value set difference block: directed and random words, scoreboarded.
module tb_unique_value_set_difference;
    import uvsd_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // Action code with no meaning; the block must drop such words
    localparam logic [1:0] ACT_UNUSED = 2'd3;
    // Cycles without any accepted word before the run is called hung
    localparam int STALL_LIMIT = 2000;
    // Long receiver hold-off for the backpressure test
    localparam int HOLD_OFF_CYCLES = 300;
    // Settling time after the last result
    localparam int DRAIN_CYCLES = 20;
    localparam int MAX_REPORTS = 10;

    logic      i_clk = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      i_in_valid = 1'b0;
    logic      o_in_ready;
    t_in_word  i_in = '0;
    logic      o_out_valid;
    logic      i_out_ready = 1'b0;
    t_out_word o_out;

    // Shadow tables of the two sequences
    logic [1:0] first_cnt [VALUE_RANGE_DEF];
    logic       second_pres [VALUE_RANGE_DEF];

    // Expected result words, oldest first
    t_out_word singleton_q [$];

    int  mismatch_count = 0;
    int  words_sent = 0;
    int  stall_cycles = 0;
    int  hold_request = 0;
    bit  allow_gaps = 1'b1;

    unique_value_set_difference dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out       (o_out)
    );

    // 4 ns clock
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Update the shadow tables; a finish word scans them and queues its results
    task automatic apply_to_tables(input t_in_word w);
        int        found;
        t_out_word r;
        found = 0;
        case (w.action)
            ACT_FIRST: begin
                if (int'(w.item_value) < VALUE_RANGE_DEF)
                    first_cnt[w.item_value] = (first_cnt[w.item_value] == CNT_NONE) ?
                                              CNT_ONCE : CNT_MANY;
            end
            ACT_SECOND: begin
                if (int'(w.item_value) < VALUE_RANGE_DEF)
                    second_pres[w.item_value] = 1'b1;
            end
            ACT_FINISH: begin
                for (int i = 0; i < VALUE_RANGE_DEF && found < MAX_LOAD; i++) begin
                    if (first_cnt[i] == CNT_ONCE && !second_pres[i]) begin
                        r.result_value = VALUE_W'(i);
                        r.result_count = COUNT_W'(found + 1);
                        r.none_found   = 1'b0;
                        r.is_last      = 1'b0;
                        singleton_q.push_back(r);
                        found++;
                    end
                end
                if (found == 0) begin
                    r = '0;
                    r.none_found = 1'b1;
                    r.is_last    = 1'b1;
                    singleton_q.push_back(r);
                end else begin
                    singleton_q[singleton_q.size() - 1].is_last = 1'b1;
                end
                for (int i = 0; i < VALUE_RANGE_DEF; i++) begin
                    first_cnt[i]   = CNT_NONE;
                    second_pres[i] = 1'b0;
                end
            end
            default: ;
        endcase
    endtask

    // Offer one word from a falling edge, hold it until accepted, return at a falling edge
    task automatic send_word(input logic [1:0] act, input logic [VALUE_W-1:0] val);
        t_in_word w;
        w.action     = act;
        w.item_value = val;
        if (allow_gaps && $urandom_range(99) < 7) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in       <= w;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        apply_to_tables(w);
        if (act != ACT_UNUSED) words_sent++;
        @(negedge i_clk);
    endtask

    task automatic note_mismatch(input string what, input t_out_word exp_w,
                                 input t_out_word got);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS) begin
            $write("%0t: %s: expected value %0d count %0d none %0b last %0b, ",
                   $realtime, what, exp_w.result_value, exp_w.result_count,
                   exp_w.none_found, exp_w.is_last);
            $display("got value %0d count %0d none %0b last %0b",
                     got.result_value, got.result_count, got.none_found, got.is_last);
        end
    endtask

    // Compare every accepted result word with the oldest expectation
    always @(posedge i_clk) begin
        t_out_word exp_w;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (singleton_q.size() == 0) begin
                note_mismatch("unexpected result word", '0, o_out);
            end else begin
                exp_w = singleton_q.pop_front();
                if (o_out.result_value !== exp_w.result_value ||
                    o_out.result_count !== exp_w.result_count ||
                    o_out.none_found !== exp_w.none_found ||
                    o_out.is_last !== exp_w.is_last)
                    note_mismatch("result word mismatch", exp_w, o_out);
            end
        end
    end

    // Receiver: random gaps, plus a counted hold-off on request
    initial begin
        int hold_left;
        hold_left = 0;
        forever begin
            @(negedge i_clk);
            if (hold_request > 0) begin
                hold_left    = hold_request;
                hold_request = 0;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_out_ready <= 1'b0;
            end else if (allow_gaps && $urandom_range(99) < 7) begin
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= 1'b1;
            end
        end
    end

    // Watchdog: end the run when no word moves for too long
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // Finish on empty tables must report the empty set
    task automatic test_empty_finish();
        send_word(ACT_FINISH, 6'h3F);
    endtask

    // Edge values, sticky repeats, second-sequence removal and dropped unused codes
    task automatic test_mixed_loads();
        send_word(ACT_FIRST, 6'd0);
        send_word(ACT_FIRST, 6'd63);
        send_word(ACT_FIRST, 6'd5);
        send_word(ACT_FIRST, 6'd5);
        send_word(ACT_FIRST, 6'd42);
        send_word(ACT_FIRST, 6'd42);
        send_word(ACT_FIRST, 6'd42);
        send_word(ACT_FIRST, 6'd7);
        send_word(ACT_SECOND, 6'd7);
        send_word(ACT_SECOND, 6'd21);
        send_word(ACT_FIRST, 6'd9);
        // unused code on qualifying values: must not turn them into repeats
        send_word(ACT_UNUSED, 6'd0);
        send_word(ACT_UNUSED, 6'd63);
        send_word(ACT_FINISH, 6'd0);
    endtask

    // Second sequence alone qualifies nothing; tables are clear after each finish
    task automatic test_tables_cleared();
        send_word(ACT_SECOND, 6'd12);
        send_word(ACT_FINISH, 6'd12);
        send_word(ACT_FIRST, 6'd12);
        send_word(ACT_FINISH, 6'd33);
    endtask

    // Every value once, in shuffled order: the longest possible result run
    task automatic test_full_table();
        logic [VALUE_W-1:0] order [VALUE_RANGE_DEF];
        logic [VALUE_W-1:0] tmp;
        int                 j;
        for (int i = 0; i < VALUE_RANGE_DEF; i++) order[i] = VALUE_W'(i);
        for (int i = VALUE_RANGE_DEF - 1; i > 0; i--) begin
            j        = $urandom_range(i);
            tmp      = order[i];
            order[i] = order[j];
            order[j] = tmp;
        end
        for (int i = 0; i < VALUE_RANGE_DEF; i++) send_word(ACT_FIRST, order[i]);
        send_word(ACT_FINISH, '0);
    endtask

    // Hold the output off during a scan while loads keep coming, so the input stalls
    task automatic test_output_backpressure();
        allow_gaps = 1'b0;
        for (int k = 0; k < 20; k++) send_word(ACT_FIRST, VALUE_W'(k * 3));
        hold_request = HOLD_OFF_CYCLES;
        send_word(ACT_FINISH, '0);
        for (int k = 0; k < 12; k++)
            send_word(($urandom_range(2) == 0) ? ACT_SECOND : ACT_FIRST,
                      VALUE_W'($urandom_range(63)));
        send_word(ACT_FINISH, '0);
        allow_gaps = 1'b1;
    endtask

    // Runs of random loads closed by a finish; narrow value pools force repeats
    task automatic test_random_runs(input int target);
        int                 run_len;
        int                 spread;
        int                 roll;
        int                 run_idx;
        logic [VALUE_W-1:0] base;
        logic [1:0]         act;
        run_idx = 0;
        while (words_sent < target) begin
            // a stretch of runs with no gaps on either side
            allow_gaps = !(run_idx >= 6 && run_idx < 12);
            run_len = $urandom_range(0, 24);
            spread  = ($urandom_range(3) == 0) ? 63 : $urandom_range(3, 24);
            base    = VALUE_W'($urandom_range(63));
            for (int k = 0; k < run_len; k++) begin
                roll = $urandom_range(99);
                if (roll < 3)       act = ACT_UNUSED;
                else if (roll < 68) act = ACT_FIRST;
                else                act = ACT_SECOND;
                send_word(act, base + VALUE_W'($urandom_range(spread)));
            end
            send_word(ACT_FINISH, VALUE_W'($urandom_range(63)));
            run_idx++;
        end
        allow_gaps = 1'b1;
    endtask

    initial begin
        for (int i = 0; i < VALUE_RANGE_DEF; i++) begin
            first_cnt[i]   = CNT_NONE;
            second_pres[i] = 1'b0;
        end
        // Hold the synchronous reset, then release it at a falling edge
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_empty_finish();
        test_mixed_loads();
        test_tables_cleared();
        test_full_table();
        test_output_backpressure();
        test_random_runs(410);

        // Drain the outstanding results, then let the block settle
        i_in_valid <= 1'b0;
        while (singleton_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatch_count == 0 && singleton_q.size() == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
